>>> sv/psd_pkg.sv
package psd_pkg;

  // Datapath widths.
  localparam int CW  = 32;   // input coordinate
  localparam int VW  = 33;   // coordinate difference
  localparam int PW  = 66;   // product of two differences
  localparam int SW  = 67;   // sum of three products
  localparam int QB  = 34;   // quotient bits, one divider stage each
  localparam int NW  = 100;  // dividend and partial remainder
  localparam int TRW = 34;   // root bits of |d|^2
  localparam int MW  = 35;   // rounded quotient
  localparam int OW  = 36;   // signed offset along the line
  localparam int EW  = 37;   // projection, error vector and box bounds
  localparam int EMW = 36;   // error vector magnitude
  localparam int FSW = 72;   // final sum of squares
  localparam int FRW = 36;   // final root bits
  localparam int DSW = 33;   // distance output

  // Result part codes.
  localparam logic [1:0] PART_INTERIOR = 2'd0;
  localparam logic [1:0] PART_START    = 2'd1;
  localparam logic [1:0] PART_END      = 2'd2;

  // Register index.
  localparam logic REG_SEGMENT_MODE = 1'b0;

  // Geometry that rides along with a query.
  typedef struct packed {
    logic [2:0][CW-1:0] s;
    logic [2:0][CW-1:0] e;
    logic [2:0][VW-1:0] w;
    logic [2:0][VW-1:0] dmag;
    logic [2:0]         dsgn;
  } geo_t;

  // Side data carried past the divider.
  typedef struct packed {
    geo_t          geo;
    logic          dneg;
    logic          degen;
    logic [SW-1:0] near;
    logic [1:0]    npart;
  } mid_t;

  // Side data carried past the final square root.
  typedef struct packed {
    logic [1:0] part;
    logic       degen;
  } tail_t;

endpackage

>>> sv/psd_div_pipe.sv
module psd_div_pipe #(
  parameter int QB = 34,
  parameter int NW = 100,
  parameter int DW = 67
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QB-1:0] quot_o,
  output logic [NW-1:0] rem_o,
  output logic [DW-1:0] den_o
);

  logic [NW-1:0] rem_q  [QB];
  logic [QB-1:0] quot_q [QB];
  logic [DW-1:0] den_q  [QB];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [QB-1:0] quot_in;
    logic [DW-1:0] den_in;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign quot_in = '0;
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign quot_in = quot_q[k-1];
      assign den_in  = den_q[k-1];
    end

    assign trial = NW'(den_in) << B;
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_in - trial) : rem_in;
        quot_q[k] <= quot_in | (QB'(take) << B);
        den_q[k]  <= den_in;
      end
    end
  end

  assign quot_o = quot_q[QB-1];
  assign rem_o  = rem_q[QB-1];
  assign den_o  = den_q[QB-1];

endmodule

>>> sv/psd_sqrt_pipe.sv
module psd_sqrt_pipe #(
  parameter int RW = 36
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] sum_i,
  output logic [RW-1:0]   root_o,
  output logic [2*RW:0]   rem_o
);

  localparam int RMW = 2 * RW + 1;

  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];

  // Digit-by-digit square root; the remainder is the input minus root squared.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [RMW-1:0] rem_in;
    logic [RMW-1:0] trial;
    logic [RW-1:0]  root_in;
    logic           take;

    if (k == 0) begin : g_first
      assign rem_in  = RMW'(sum_i);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = (RMW'(root_in) << (B + 1)) + (RMW'(1) << (2 * B));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_in - trial) : rem_in;
        root_q[k] <= root_in | (RW'(take) << B);
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign rem_o  = rem_q[RW-1];

endmodule

>>> sv/point_segment_distance_3d.sv
// Distance from a query point to a 3-D segment or line, signed Q16.16 inputs.
// Input channel: valid_i/stall_o carry one query (point, start, end) per
// transaction. Output channel: valid_o/stall_i carry distance, nearest part and
// the degenerate flag. A transaction completes when valid is high and stall low.
// Throughput is one query per cycle unless a held result stalls the pipeline.
// Registered stages form differences, products and the dot product, a 34-stage
// divider projects the point, further stages round, test the box and select the
// squared distance, and a 36-stage square root gives the length.
// The whole pipeline advances together; while a result sits on the output and
// stall_i is high, every stage holds and stall_o is raised, so nothing is lost
// or repeated. The segment_mode register sits at byte address 0 of the APB port
// and resets to 1; write it only while no query is in flight. Reset empties the
// pipeline at once, with no clearing pass.
module point_segment_distance_3d #(
  parameter int TOL_SHIFT = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] start_z_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic signed [31:0] end_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [32:0]        distance_o,
  output logic [1:0]         nearest_part_o,
  output logic               degenerate_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import psd_pkg::*;

  localparam int LAT = 6 + QB + 5 + FRW + 1;

  function automatic logic [VW-1:0] mag_v(input logic signed [VW-1:0] x);
    return x[VW-1] ? (~x + 1'b1) : x;
  endfunction

  function automatic logic [EW-1:0] mag_e(input logic signed [EW-1:0] x);
    return x[EW-1] ? (~x + 1'b1) : x;
  endfunction

  logic           en;
  logic [LAT-1:0] vpipe_q;
  logic           seg_mode_q;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEGMENT_MODE) ? {31'b0, seg_mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_mode_q <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_SEGMENT_MODE)) begin
      seg_mode_q <= pwdata[0];
    end
  end

  // The pipeline advances unless a finished result is held by the receiver.
  assign en      = !(vpipe_q[LAT-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vpipe_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q <= '0;
    end else if (en) begin
      vpipe_q <= {vpipe_q[LAT-2:0], valid_i};
    end
  end

  // Stage 1: difference vectors.
  logic signed [CW-1:0] pt [3];
  logic signed [CW-1:0] st [3];
  logic signed [CW-1:0] ed [3];
  logic signed [VW-1:0] d1_q [3];
  logic signed [VW-1:0] w1_q [3];
  logic signed [VW-1:0] u1_q [3];
  logic signed [CW-1:0] s1_q [3];
  logic signed [CW-1:0] e1_q [3];

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign st[0] = start_x_i;
  assign st[1] = start_y_i;
  assign st[2] = start_z_i;
  assign ed[0] = end_x_i;
  assign ed[1] = end_y_i;
  assign ed[2] = end_z_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= VW'(ed[i]) - VW'(st[i]);
        w1_q[i] <= VW'(pt[i]) - VW'(st[i]);
        u1_q[i] <= VW'(pt[i]) - VW'(ed[i]);
        s1_q[i] <= st[i];
        e1_q[i] <= ed[i];
      end
    end
  end

  // Stage 2: squares and axis products of magnitudes.
  logic [PW-1:0] dsq2_q [3];
  logic [PW-1:0] wsq2_q [3];
  logic [PW-1:0] usq2_q [3];
  logic [PW-1:0] wd2_q  [3];
  logic [2:0]    wdn2_q;
  geo_t          geo2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dsq2_q[i]         <= PW'(mag_v(d1_q[i])) * PW'(mag_v(d1_q[i]));
        wsq2_q[i]         <= PW'(mag_v(w1_q[i])) * PW'(mag_v(w1_q[i]));
        usq2_q[i]         <= PW'(mag_v(u1_q[i])) * PW'(mag_v(u1_q[i]));
        wd2_q[i]          <= PW'(mag_v(w1_q[i])) * PW'(mag_v(d1_q[i]));
        wdn2_q[i]         <= w1_q[i][VW-1] ^ d1_q[i][VW-1];
        geo2_q.s[i]       <= s1_q[i];
        geo2_q.e[i]       <= e1_q[i];
        geo2_q.w[i]       <= w1_q[i];
        geo2_q.dmag[i]    <= mag_v(d1_q[i]);
        geo2_q.dsgn[i]    <= d1_q[i][VW-1];
      end
    end
  end

  // Stage 3: sums of squares and the signed halves of the dot product.
  logic [SW-1:0] dd3_q, sq03_q, sq13_q, pos3_q, neg3_q;
  logic [SW-1:0] pos_sum, neg_sum;
  geo_t          geo3_q;

  always_comb begin
    pos_sum = '0;
    neg_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (wdn2_q[i]) begin
        neg_sum = neg_sum + SW'(wd2_q[i]);
      end else begin
        pos_sum = pos_sum + SW'(wd2_q[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd3_q  <= SW'(dsq2_q[0]) + SW'(dsq2_q[1]) + SW'(dsq2_q[2]);
      sq03_q <= SW'(wsq2_q[0]) + SW'(wsq2_q[1]) + SW'(wsq2_q[2]);
      sq13_q <= SW'(usq2_q[0]) + SW'(usq2_q[1]) + SW'(usq2_q[2]);
      pos3_q <= pos_sum;
      neg3_q <= neg_sum;
      geo3_q <= geo2_q;
    end
  end

  // Stage 4: dot product magnitude, degenerate test, nearer endpoint.
  logic [SW-1:0] dd4_q, dotm4_q;
  mid_t          mid4_d, mid4_q;

  always_comb begin
    mid4_d.geo   = geo3_q;
    mid4_d.dneg  = (pos3_q < neg3_q);
    mid4_d.degen = (dd3_q == '0);
    if (mid4_d.degen || (sq03_q < sq13_q)) begin
      mid4_d.near  = sq03_q;
      mid4_d.npart = PART_START;
    end else begin
      mid4_d.near  = sq13_q;
      mid4_d.npart = PART_END;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd4_q   <= dd3_q;
      dotm4_q <= mid4_d.dneg ? (neg3_q - pos3_q) : (pos3_q - neg3_q);
      mid4_q  <= mid4_d;
    end
  end

  // Stage 5: dot * |d_i| as two partial products.
  logic [PW-1:0] pl5_q [3];
  logic [SW-1:0] ph5_q [3];
  logic [SW-1:0] dd5_q;
  mid_t          mid5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl5_q[i] <= PW'(dotm4_q[VW-1:0]) * PW'(mid4_q.geo.dmag[i]);
        ph5_q[i] <= SW'(dotm4_q[SW-1:VW]) * SW'(mid4_q.geo.dmag[i]);
      end
      dd5_q  <= dd4_q;
      mid5_q <= mid4_q;
    end
  end

  // Stage 6: dividends.
  logic [NW-1:0] num6_q [3];
  logic [SW-1:0] dd6_q;
  mid_t          mid6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num6_q[i] <= NW'(pl5_q[i]) + (NW'(ph5_q[i]) << VW);
      end
      dd6_q  <= dd5_q;
      mid6_q <= mid5_q;
    end
  end

  // Dividers per axis, with the root of |d|^2 alongside for the tolerance.
  logic [QB-1:0]  quot [3];
  logic [NW-1:0]  rem  [3];
  logic [SW-1:0]  dden;
  logic [TRW-1:0] troot;
  mid_t           midd_q [QB];

  psd_div_pipe #(.QB(QB), .NW(NW), .DW(SW)) u_div0 (
    .clk_i (clk_i), .en_i (en), .num_i (num6_q[0]), .den_i (dd6_q),
    .quot_o(quot[0]), .rem_o (rem[0]), .den_o (dden)
  );

  psd_div_pipe #(.QB(QB), .NW(NW), .DW(SW)) u_div1 (
    .clk_i (clk_i), .en_i (en), .num_i (num6_q[1]), .den_i (dd6_q),
    .quot_o(quot[1]), .rem_o (rem[1]), .den_o ()
  );

  psd_div_pipe #(.QB(QB), .NW(NW), .DW(SW)) u_div2 (
    .clk_i (clk_i), .en_i (en), .num_i (num6_q[2]), .den_i (dd6_q),
    .quot_o(quot[2]), .rem_o (rem[2]), .den_o ()
  );

  psd_sqrt_pipe #(.RW(TRW)) u_tol_sqrt (
    .clk_i (clk_i), .en_i (en), .sum_i ((2*TRW)'(dd6_q)),
    .root_o(troot), .rem_o ()
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      midd_q[0] <= mid6_q;
      for (int k = 1; k < QB; k++) begin
        midd_q[k] <= midd_q[k-1];
      end
    end
  end

  // Stage 7: round quotients to nearest, halves up; tolerance.
  logic [MW-1:0]  m7_q [3];
  logic [TRW-1:0] tol7_q;
  mid_t           mid7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m7_q[i] <= MW'(quot[i]) + MW'({rem[i], 1'b0} >= (NW+1)'(dden));
      end
      tol7_q <= TRW'(troot >> TOL_SHIFT);
      mid7_q <= midd_q[QB-1];
    end
  end

  // Stage 8: signed offsets, projection, error vector, widened box.
  logic signed [EW-1:0] proj8_q [3];
  logic signed [EW-1:0] ev8_q   [3];
  logic signed [EW-1:0] lo8_q   [3];
  logic signed [EW-1:0] hi8_q   [3];
  mid_t                 mid8_q;
  logic signed [OW-1:0] off    [3];
  logic signed [CW-1:0] sv     [3];
  logic signed [CW-1:0] evx    [3];
  logic signed [EW-1:0] tol_s;

  assign tol_s = $signed({{(EW-TRW){1'b0}}, tol7_q});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv[i]  = $signed(mid7_q.geo.s[i]);
      evx[i] = $signed(mid7_q.geo.e[i]);
      off[i] = $signed(OW'(m7_q[i]));
      if (mid7_q.dneg ^ mid7_q.geo.dsgn[i]) begin
        off[i] = -off[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        proj8_q[i] <= EW'(sv[i]) + EW'(off[i]);
        ev8_q[i]   <= EW'(off[i]) - EW'($signed(mid7_q.geo.w[i]));
        lo8_q[i]   <= ((sv[i] < evx[i]) ? EW'(sv[i]) : EW'(evx[i])) - tol_s;
        hi8_q[i]   <= ((sv[i] < evx[i]) ? EW'(evx[i]) : EW'(sv[i])) + tol_s;
      end
      mid8_q <= mid7_q;
    end
  end

  // Stage 9: strict box test on every axis; error magnitudes.
  logic           inside9_q;
  logic [EMW-1:0] evm9_q [3];
  mid_t           mid9_q;
  logic           inside9_d;

  always_comb begin
    inside9_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (!((lo8_q[i] < proj8_q[i]) && (proj8_q[i] < hi8_q[i]))) begin
        inside9_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        evm9_q[i] <= EMW'(mag_e(ev8_q[i]));
      end
      inside9_q <= inside9_d;
      mid9_q    <= mid8_q;
    end
  end

  // Stage 10: error squares.
  logic [FSW-1:0] evsq10_q [3];
  logic           inside10_q;
  mid_t           mid10_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        evsq10_q[i] <= FSW'(evm9_q[i]) * FSW'(evm9_q[i]);
      end
      inside10_q <= inside9_q;
      mid10_q    <= mid9_q;
    end
  end

  // Stage 11: pick the squared distance to report.
  logic [FSW-1:0] sel11_q;
  tail_t          tail11_q;
  logic [FSW-1:0] evsum;

  assign evsum = evsq10_q[0] + evsq10_q[1] + evsq10_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (mid10_q.degen) begin
        sel11_q        <= FSW'(mid10_q.near);
        tail11_q.part  <= PART_START;
        tail11_q.degen <= 1'b1;
      end else if (!seg_mode_q || inside10_q) begin
        sel11_q        <= evsum;
        tail11_q.part  <= PART_INTERIOR;
        tail11_q.degen <= 1'b0;
      end else begin
        sel11_q        <= FSW'(mid10_q.near);
        tail11_q.part  <= mid10_q.npart;
        tail11_q.degen <= 1'b0;
      end
    end
  end

  // Final square root.
  logic [FRW-1:0] froot;
  logic [2*FRW:0] frem;
  tail_t          tail_q [FRW];

  psd_sqrt_pipe #(.RW(FRW)) u_dist_sqrt (
    .clk_i (clk_i), .en_i (en), .sum_i (sel11_q),
    .root_o(froot), .rem_o (frem)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_q[0] <= tail11_q;
      for (int k = 1; k < FRW; k++) begin
        tail_q[k] <= tail_q[k-1];
      end
    end
  end

  // Output register: round the root to nearest and saturate.
  logic [FRW:0]     rounded;
  logic [DSW-1:0]   dist_q;
  tail_t            tail_out_q;

  assign rounded = (FRW+1)'(froot) + (FRW+1)'(frem > (2*FRW+1)'(froot));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q     <= (rounded[FRW:DSW] != '0) ? '1 : rounded[DSW-1:0];
      tail_out_q <= tail_q[FRW-1];
    end
  end

  assign distance_o     = dist_q;
  assign nearest_part_o = tail_out_q.part;
  assign degenerate_o   = tail_out_q.degen;

  // A coincident pair always reports the first endpoint.
  a_degen_part : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (nearest_part_o == PART_START))
    else $error("degenerate result without first endpoint");

  // Only the three defined part codes leave the block.
  a_part_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (nearest_part_o == PART_INTERIOR || nearest_part_o == PART_START ||
                 nearest_part_o == PART_END))
    else $error("undefined nearest part code");

  // Line mode never clamps to an endpoint.
  a_line_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !seg_mode_q && !degenerate_o) |-> (nearest_part_o == PART_INTERIOR))
    else $error("line mode result clamped to an endpoint");

endmodule
